// ===== sv/svm_pkg.sv =====
`timescale 1ns / 1ps

package svm_pkg;

	// store geometry
	localparam int VERTEX_COUNT     = 4096;
	localparam int MAX_COMPONENTS   = 4;
	localparam int FIELD_COMPONENTS = 4;
	localparam int LANES            = (MAX_COMPONENTS < FIELD_COMPONENTS) ?
		MAX_COMPONENTS : FIELD_COMPONENTS;
	localparam int ADDR_W           = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

	// field widths
	localparam int IDX_W   = 12;
	localparam int VAL_W   = 32;
	localparam int SUM_W   = 48;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 3;
	localparam int NCOMP_W = CFG_W;

	localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// divider runs one quotient bit per step
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [VAL_W-1:0] val_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic {
		OP_ACCUM = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_DIV
	} state_t;

	// one memory word per vertex: all component sums and the count
	typedef struct packed {
		sum_t [LANES-1:0]   sums;
		logic [CNT_W-1:0]   count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// 48-bit add of a sign-extended component, clamped to the sum range
	function automatic sum_t sat_add(sum_t s, val_t v);
		logic [SUM_W:0] t;
		t = {s[SUM_W-1], s} + {{(SUM_W+1-VAL_W){v[VAL_W-1]}}, v};
		if (t[SUM_W] != t[SUM_W-1]) begin
			return t[SUM_W] ? SUM_MIN : SUM_MAX;
		end
		return sum_t'(t[SUM_W-1:0]);
	endfunction

	// components in use: zero acts as one, clamp to the lanes present
	function automatic logic [NCOMP_W-1:0] active_count(logic [CFG_W-1:0] c);
		logic [NCOMP_W-1:0] n;
		n = c;
		if (n == '0) begin
			n = NCOMP_W'(1);
		end
		if (n > NCOMP_W'(LANES)) begin
			n = NCOMP_W'(LANES);
		end
		return n;
	endfunction

endpackage

// ===== sv/svm_ram.sv =====
`timescale 1ns / 1ps

module svm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port, read returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/svm_div.sv =====
`timescale 1ns / 1ps

module svm_div (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             start,
	input  svm_pkg::sum_t [svm_pkg::FIELD_COMPONENTS-1:0]    dividend,
	input  logic [svm_pkg::CNT_W-1:0]                        divisor,
	output logic                                             done,
	output svm_pkg::val_t [svm_pkg::FIELD_COMPONENTS-1:0]    quot
);

	import svm_pkg::*;

	localparam logic [SUM_W-1:0] POS_LIM = SUM_W'(2**(VAL_W-1)-1);
	localparam logic [SUM_W-1:0] NEG_LIM = POS_LIM + SUM_W'(1);

	logic [SUM_W-1:0] work_q  [FIELD_COMPONENTS];
	logic [CNT_W-1:0] rem_q   [FIELD_COMPONENTS];
	logic [SUM_W-1:0] work_nx [FIELD_COMPONENTS];
	logic [CNT_W-1:0] rem_nx  [FIELD_COMPONENTS];
	logic [SUM_W-1:0] neg_mag [FIELD_COMPONENTS];
	logic [FIELD_COMPONENTS-1:0] neg_q;
	logic [CNT_W-1:0] dsr_q;
	logic [STEP_W-1:0] step_q;
	logic run_q;
	logic done_q;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIV_STEPS-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one restoring step per lane on magnitudes
	always_comb begin
		logic [CNT_W:0] trial;
		logic ge;
		for (int k = 0; k < FIELD_COMPONENTS; k++) begin
			trial = {rem_q[k], work_q[k][SUM_W-1]};
			ge = (trial >= {1'b0, dsr_q});
			rem_nx[k] = ge ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
			work_nx[k] = {work_q[k][SUM_W-2:0], ge};
		end
	end

	// lane registers: load magnitudes, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			for (int k = 0; k < FIELD_COMPONENTS; k++) begin
				neg_q[k]  <= dividend[k][SUM_W-1];
				rem_q[k]  <= '0;
				work_q[k] <= dividend[k][SUM_W-1] ? SUM_W'(-dividend[k]) :
					SUM_W'(dividend[k]);
			end
		end else if (run_q) begin
			for (int k = 0; k < FIELD_COMPONENTS; k++) begin
				rem_q[k]  <= rem_nx[k];
				work_q[k] <= work_nx[k];
			end
		end
	end

	// restore sign and clamp to 32 bits
	always_comb begin
		for (int k = 0; k < FIELD_COMPONENTS; k++) begin
			neg_mag[k] = SUM_W'(-work_q[k]);
			if (neg_q[k]) begin
				quot[k] = (work_q[k] > NEG_LIM) ? VAL_MIN : val_t'(neg_mag[k][VAL_W-1:0]);
			end else begin
				quot[k] = (work_q[k] > POS_LIM) ? VAL_MAX : val_t'(work_q[k][VAL_W-1:0]);
			end
		end
	end

	assign done = done_q;

endmodule

// ===== sv/vertex_attribute_scatter_mean_top.sv =====
`timescale 1ns / 1ps
// accumulate words: one per cycle while busy is low, written back on the cycle after acceptance
// read words: for an empty vertex the result strobe comes from stage 1 through the done register;
//   otherwise it waits on the 48-step bit-serial divider that serves all four components at once
// after reset the block clears its 4096-entry store, one entry a cycle, with busy high
// results are strobed by done for one cycle; the receiver cannot stall

module vertex_attribute_scatter_mean_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic                          face_valid,
	input  logic [svm_pkg::IDX_W-1:0]     vertex_index,
	input  logic signed [svm_pkg::VAL_W-1:0] value_0,
	input  logic signed [svm_pkg::VAL_W-1:0] value_1,
	input  logic signed [svm_pkg::VAL_W-1:0] value_2,
	input  logic signed [svm_pkg::VAL_W-1:0] value_3,
	output logic                          done,
	output logic [svm_pkg::IDX_W-1:0]     out_vertex_index,
	output logic                          vertex_valid,
	output logic [svm_pkg::CNT_W-1:0]     contribution_count,
	output logic signed [svm_pkg::VAL_W-1:0] average_0,
	output logic signed [svm_pkg::VAL_W-1:0] average_1,
	output logic signed [svm_pkg::VAL_W-1:0] average_2,
	output logic signed [svm_pkg::VAL_W-1:0] average_3,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [svm_pkg::CFG_W-1:0]     cfg_data
);

	import svm_pkg::*;

	state_t state_q, state_nx;
	logic [ADDR_W-1:0] clr_q;
	logic [CFG_W-1:0] cfg_q;
	logic [NCOMP_W-1:0] n_act;
	logic accept;
	logic busy_c;

	// stage 1: item waiting on memory read data
	logic valid_s1;
	op_t op_s1;
	logic fv_s1;
	logic inr_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [ADDR_W-1:0] addr_s1;
	val_t val_s1 [FIELD_COMPONENTS];

	// last write, for a read issued at the same edge
	logic fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	entry_t fwd_data_q;

	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	entry_t old_e;
	entry_t acc_e;
	logic [CNT_W-1:0] rd_count;

	logic div_start;
	logic div_done;
	sum_t [FIELD_COMPONENTS-1:0] div_dividend;
	val_t [FIELD_COMPONENTS-1:0] div_quot;

	logic done_q;
	logic [IDX_W-1:0] res_idx_q;
	logic res_valid_q;
	logic [CNT_W-1:0] res_count_q;
	val_t res_avg_q [FIELD_COMPONENTS];

	assign accept = start && !busy_c;
	assign n_act  = active_count(cfg_q);

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// sum and count store
	svm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(VERTEX_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ADDR_W'(vertex_index)),
		.rdata(ram_rdata)
	);

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(opcode);
			fv_s1   <= face_valid;
			inr_s1  <= (32'(vertex_index) < 32'(VERTEX_COUNT));
			idx_s1  <= vertex_index;
			addr_s1 <= ADDR_W'(vertex_index);
			val_s1[0] <= value_0;
			val_s1[1] <= value_1;
			val_s1[2] <= value_2;
			val_s1[3] <= value_3;
		end
	end

	// forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= ram_waddr;
		fwd_data_q <= entry_t'(ram_wdata);
	end

	// entry as seen by stage 1
	assign old_e = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : entry_t'(ram_rdata);
	assign rd_count = inr_s1 ? old_e.count : '0;

	// accumulate update
	always_comb begin
		acc_e = old_e;
		for (int k = 0; k < LANES; k++) begin
			if (NCOMP_W'(k) < n_act) begin
				acc_e.sums[k] = sat_add(old_e.sums[k], val_s1[k]);
			end
		end
		if (old_e.count != COUNT_MAX) begin
			acc_e.count = old_e.count + CNT_W'(1);
		end
	end

	// divider operands, idle lanes divide zero
	for (genvar k = 0; k < FIELD_COMPONENTS; k++) begin : g_dvd
		if (k < LANES) begin : g_lane
			assign div_dividend[k] = (NCOMP_W'(k) < n_act) ? old_e.sums[k] : '0;
		end else begin : g_none
			assign div_dividend[k] = '0;
		end
	end

	svm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (rd_count),
		.done    (div_done),
		.quot    (div_quot)
	);

	// state register and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	// next state, memory write and divider start
	always_comb begin
		state_nx  = state_q;
		busy_c    = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = '0;
		div_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == ADDR_W'(VERTEX_COUNT-1)) begin
					state_nx = ST_RUN;
				end
			end
			ST_RUN: begin
				busy_c = valid_s1 && (op_s1 == OP_READ);
				if (valid_s1) begin
					if (op_s1 == OP_ACCUM) begin
						ram_we    = fv_s1 && inr_s1;
						ram_wdata = acc_e;
					end else begin
						// read clears the entry at once
						ram_we = inr_s1;
						if (rd_count != '0) begin
							div_start = 1'b1;
							state_nx  = ST_DIV;
						end
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_nx = ST_RUN;
				end
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

	assign busy = busy_c;

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == ST_RUN) && valid_s1 && (op_s1 == OP_READ) &&
				(rd_count == '0)) || ((state_q == ST_DIV) && div_done);
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && valid_s1 && (op_s1 == OP_READ)) begin
			res_idx_q   <= idx_s1;
			res_count_q <= rd_count;
			res_valid_q <= (rd_count != '0);
			for (int k = 0; k < FIELD_COMPONENTS; k++) begin
				res_avg_q[k] <= '0;
			end
		end else if ((state_q == ST_DIV) && div_done) begin
			for (int k = 0; k < FIELD_COMPONENTS; k++) begin
				res_avg_q[k] <= div_quot[k];
			end
		end
	end

	assign done               = done_q;
	assign out_vertex_index   = res_idx_q;
	assign vertex_valid       = res_valid_q;
	assign contribution_count = res_count_q;
	assign average_0          = res_avg_q[0];
	assign average_1          = res_avg_q[1];
	assign average_2          = res_avg_q[2];
	assign average_3          = res_avg_q[3];

endmodule

// ===== sv/svm_check.sv =====
`timescale 1ns / 1ps

module svm_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              opcode,
	input logic                              done,
	input logic                              vertex_valid,
	input logic [svm_pkg::CNT_W-1:0]         contribution_count,
	input logic signed [svm_pkg::VAL_W-1:0]  average_0,
	input logic signed [svm_pkg::VAL_W-1:0]  average_1,
	input logic signed [svm_pkg::VAL_W-1:0]  average_2,
	input logic signed [svm_pkg::VAL_W-1:0]  average_3
);

	import svm_pkg::*;

	// a read word holds off the next word while its entry is fetched
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_READ) |=> busy)
		else $error("read word not followed by busy");

	// an accumulate word never produces a result
	a_accum_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_ACCUM) |-> ##2 !done)
		else $error("result strobe after accumulate word");

	// an empty vertex reports zero count and zero averages
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !vertex_valid |-> (contribution_count == '0) && (average_0 == '0) &&
		(average_1 == '0) && (average_2 == '0) && (average_3 == '0))
		else $error("empty vertex with nonzero result");

	// a valid vertex carries a nonzero count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && vertex_valid |-> (contribution_count != '0))
		else $error("valid vertex with zero count");

endmodule

bind vertex_attribute_scatter_mean_top svm_check u_check (.*);
